/* src/fsce_pkg.sv */
// Package: shared constants, types and helpers of the format string character emitter.
`timescale 1ns / 1ps

package fsce_pkg;

  localparam int CHAR_W     = 8;
  localparam int ARG_W      = 64;
  localparam int NIB_W      = 4;
  localparam int DEC_DIGITS = 20;
  localparam int BCD_W      = DEC_DIGITS * NIB_W;
  localparam int HEX_DIGITS = ARG_W / NIB_W;
  localparam int CNT_W      = 6;

  // Step counter end values.
  localparam logic [CNT_W-1:0] HEX_LAST = CNT_W'(HEX_DIGITS - 1);
  localparam logic [CNT_W-1:0] DD_LAST  = CNT_W'(ARG_W - 1);
  localparam logic [CNT_W-1:0] DEC_LAST = CNT_W'(DEC_DIGITS - 1);

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_PCT  = 8'h25;
  localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C    = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D    = 8'h64;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_U    = 8'h75;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h78;

  // Output character selection codes.
  localparam logic [2:0] SEL_CH    = 3'd0;
  localparam logic [2:0] SEL_CR    = 3'd1;
  localparam logic [2:0] SEL_PCT   = 3'd2;
  localparam logic [2:0] SEL_ARGLO = 3'd3;
  localparam logic [2:0] SEL_ZERO  = 3'd4;
  localparam logic [2:0] SEL_X     = 3'd5;
  localparam logic [2:0] SEL_HEX   = 3'd6;
  localparam logic [2:0] SEL_DEC   = 3'd7;

  typedef struct packed {
    logic       load_in;
    logic       emit;
    logic [2:0] sel;
    logic       last;
    logic       dd_step;
    logic       dec_skip;
  } fsce_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_pct;
    logic is_nl;
    logic is_x;
    logic is_du;
    logic is_l;
    logic is_c;
    logic top_zero;
  } fsce_stat_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-NIB_W){1'b0}}, nib};
    if (nib < NIB_W'(10)) begin
      hex_char = CH_ZERO + wide;
    end else begin
      hex_char = CH_A + wide - CHAR_W'(10);
    end
  endfunction

endpackage

/* src/fsce_in_if.sv */
// Interface: input channel carrying one format character and its argument.
`timescale 1ns / 1ps

interface fsce_in_if;
  import fsce_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] format_char;
  logic [ARG_W-1:0]  argument;

  modport source (output valid, output format_char, output argument, input ready);
  modport sink (input valid, input format_char, input argument, output ready);
endinterface

/* src/fsce_out_if.sv */
// Interface: result channel carrying one output character and its last flag.
`timescale 1ns / 1ps

interface fsce_out_if;
  import fsce_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

/* src/fsce_datapath.sv */
// Datapath: character and argument registers, BCD converter and output register.
`timescale 1ns / 1ps

module fsce_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fsce_pkg::CHAR_W-1:0]   in_format_char,
  input  logic [fsce_pkg::ARG_W-1:0]    in_argument,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [fsce_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last,
  input  fsce_pkg::fsce_cmd_t           cmd,
  output fsce_pkg::fsce_stat_t          st
);
  import fsce_pkg::*;

  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [ARG_W-1:0]  arg_r, arg_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [BCD_W-1:0]  bcd_adj;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CHAR_W-1:0] sel_char;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[i*NIB_W +: NIB_W] >= NIB_W'(5)) begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd_r[i*NIB_W +: NIB_W] + NIB_W'(3);
      end else begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd_r[i*NIB_W +: NIB_W];
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_CH:    sel_char = ch_r;
      SEL_CR:    sel_char = CH_CR;
      SEL_PCT:   sel_char = CH_PCT;
      SEL_ARGLO: sel_char = arg_r[CHAR_W-1:0];
      SEL_ZERO:  sel_char = CH_ZERO;
      SEL_X:     sel_char = CH_X;
      SEL_HEX:   sel_char = hex_char(arg_r[ARG_W-1 -: NIB_W]);
      SEL_DEC:   sel_char = CH_ZERO + {{(CHAR_W-NIB_W){1'b0}}, bcd_r[BCD_W-1 -: NIB_W]};
      default:   sel_char = ch_r;
    endcase
  end

  always_comb begin
    ch_nxt  = ch_r;
    arg_nxt = arg_r;
    bcd_nxt = bcd_r;
    if (cmd.load_in) begin
      ch_nxt  = in_format_char;
      arg_nxt = in_argument;
      bcd_nxt = '0;
    end else if (cmd.dd_step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], arg_r[ARG_W-1]};
      arg_nxt = {arg_r[ARG_W-2:0], 1'b0};
    end else if (cmd.dec_skip || (cmd.emit && cmd.sel == SEL_DEC)) begin
      bcd_nxt = {bcd_r[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
    end else if (cmd.emit && cmd.sel == SEL_HEX) begin
      arg_nxt = {arg_r[ARG_W-NIB_W-1:0], {NIB_W{1'b0}}};
    end
  end

  always_comb begin
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = sel_char;
      out_last_nxt  = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    arg_r      <= arg_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    st.out_free = !out_valid_r || out_ready;
    st.is_pct   = (ch_r == CH_PCT);
    st.is_nl    = (ch_r == CH_NL);
    st.is_x     = (ch_r == CH_X);
    st.is_du    = (ch_r == CH_D) || (ch_r == CH_U);
    st.is_l     = (ch_r == CH_L);
    st.is_c     = (ch_r == CH_C);
    st.top_zero = (bcd_r[BCD_W-1 -: NIB_W] == '0);
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

/* src/fsce_ctrl.sv */
// Controller: state machine sequencing decode, conversion and character emission.
`timescale 1ns / 1ps

module fsce_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  output logic                  in_ready,
  input  fsce_pkg::fsce_stat_t  st,
  output fsce_pkg::fsce_cmd_t   cmd
);
  import fsce_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ONE    = 3'd2;
  localparam logic [2:0] S_X      = 3'd3;
  localparam logic [2:0] S_HEX    = 3'd4;
  localparam logic [2:0] S_CONV   = 3'd5;
  localparam logic [2:0] S_SKIPZ  = 3'd6;
  localparam logic [2:0] S_DEC    = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic             esc_r, esc_nxt;
  logic             skip_r, skip_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    esc_nxt   = esc_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (skip_r && st.is_du) begin
          // A 'u' or 'd' straight after a long conversion is swallowed.
          skip_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else if (esc_r) begin
          if (st.is_du || st.is_l) begin
            esc_nxt   = 1'b0;
            skip_nxt  = st.is_l;
            cnt_nxt   = '0;
            state_nxt = S_CONV;
          end else if (st.out_free) begin
            esc_nxt  = 1'b0;
            skip_nxt = 1'b0;
            cmd.emit = 1'b1;
            if (st.is_x) begin
              cmd.sel   = SEL_ZERO;
              state_nxt = S_X;
            end else if (st.is_c) begin
              cmd.sel   = SEL_ARGLO;
              cmd.last  = 1'b1;
              state_nxt = S_IDLE;
            end else if (st.is_pct) begin
              cmd.sel   = SEL_PCT;
              cmd.last  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.sel   = SEL_PCT;
              state_nxt = S_ONE;
            end
          end
        end else if (st.is_pct) begin
          esc_nxt   = 1'b1;
          skip_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          skip_nxt = 1'b0;
          cmd.emit = 1'b1;
          if (st.is_nl) begin
            cmd.sel   = SEL_CR;
            state_nxt = S_ONE;
          end else begin
            cmd.sel   = SEL_CH;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_ONE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CH;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_X: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_X;
          cnt_nxt   = '0;
          state_nxt = S_HEX;
        end
      end
      S_HEX: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_HEX;
          cmd.last = (cnt_r == HEX_LAST);
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (cnt_r == HEX_LAST) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CONV: begin
        cmd.dd_step = 1'b1;
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (cnt_r == DD_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_SKIPZ;
        end
      end
      S_SKIPZ: begin
        // Drop leading zero digits, always keeping the units digit.
        if (st.top_zero && cnt_r != DEC_LAST) begin
          cmd.dec_skip = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_DEC;
          cmd.last = (cnt_r == DEC_LAST);
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (cnt_r == DEC_LAST) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      esc_r   <= 1'b0;
      skip_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      esc_r   <= esc_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* src/format_string_char_emitter.sv */
// Top level: format string character emitter, controller plus datapath.
`timescale 1ns / 1ps

//  Channel  | Direction | Payload                      | Handshake
//  ---------+-----------+------------------------------+-------------
//  in_ch    | sink      | format_char[7:0], argument   | valid/ready
//  out_ch   | source    | out_char[7:0], last          | valid/ready
//
// An item is decoded in the cycle after it is taken. A plain character, a
// percent escape or a character conversion then emits one character, and a
// newline or an unknown escape two. A hexadecimal conversion emits 0x and
// sixteen digits. A decimal conversion runs shift-and-add-three in the BCD
// converter over the 64 argument bits, drops leading zero digits, then emits
// the remaining digits; the converter shifts one argument bit a cycle.
// Reset is synchronous and active low; it clears the escape and skip flags,
// the controller and the output valid bit.
// A stalled result holds the emission sequence in place, while the output
// register still lets the next item in once the current one is fully emitted.

module format_string_char_emitter (
  input  logic        clk,
  input  logic        rst_n,
  fsce_in_if.sink     in_ch,
  fsce_out_if.source  out_ch
);
  import fsce_pkg::*;

  fsce_cmd_t  cmd;
  fsce_stat_t st;
  logic       in_ready;
  logic       in_accept;

  // The controller owns the escape and long-skip flags and all sequencing;
  // the datapath only holds the item and produces characters on command.
  assign in_accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  fsce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd)
  );

  fsce_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_format_char (in_ch.format_char),
    .in_argument    (in_ch.argument),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_char       (out_ch.out_char),
    .out_last       (out_ch.last),
    .cmd            (cmd),
    .st             (st)
  );

  // An accepted item is always decoded before the next one is taken.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("input accepted on two consecutive cycles");

  // The controller never overwrites a result that is still waiting.
  a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("emission into an occupied output register");

  // Conversion steps and emissions never overlap on the shared registers.
  a_conv_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dd_step |-> !cmd.emit && !cmd.load_in)
    else $error("conversion step coincides with emission or load");

endmodule
